FILE: rtl/planar_odometry_integrator_unit_defines.svh
// Assertion macros shared by the odometry integrator sources.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_UNIT_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk_i with reset disabling.
`define POIU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i with reset disabling.
`define POIU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/poiu_pkg.sv
// Shared constants, types and tables of the odometry integrator.
`timescale 1ns / 1ps
package poiu_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int POS_BITS   = 32;
  localparam int STEP_W     = 24;
  localparam int CORDIC_ROUNDS = 24;
  localparam int ROUND_W    = 5;
  localparam int GUARD      = 16;
  localparam int GAIN_SHIFT = 31 - GUARD;
  // CORDIC working widths: vector with guard bits, and angle with fold headroom.
  localparam int XW = 42;
  localparam int ZW = 34;
  localparam int MUL_W = 33;
  localparam int SUM_W = ((POS_BITS > XW) ? POS_BITS : XW) + 1;
  localparam int HEAD_SHIFT = 32 - ANGLE_BITS;
  localparam int HALF_SHIFT = 31 - ANGLE_BITS;
  localparam logic signed [MUL_W-1:0] GAIN_Q31 = 33'sd1304065748;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DIST  = 2'd0;
  localparam logic [1:0] CFG_ANGLE = 2'd1;
  localparam logic [1:0] CFG_TIME  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_GAIN_DR,
    OP_FOLD,
    OP_ROT,
    OP_STEP,
    OP_GAIN_DX,
    OP_GAIN_DY,
    OP_POSE,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_T,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [ROUND_W-1:0] round;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  // Arctangent of 2^-i in 32-bit binary angle units.
  function automatic logic [31:0] atan_lut(input logic [ROUND_W-1:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/poiu_ctrl.sv
// Sequencer that steps the datapath through one odometry update.
`timescale 1ns / 1ps
module poiu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  poiu_pkg::status_t status_i,
  output poiu_pkg::cmd_t    cmd_o
);
  import poiu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_GAIN_DR, S_FOLD1, S_ROT1, S_STEP, S_GAIN_DX, S_GAIN_DY,
    S_FOLD2, S_ROT2, S_POSE, S_SQX, S_SQY, S_SQT, S_DONE
  } state_e;

  localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(CORDIC_ROUNDS - 1);

  state_e             state_q;
  logic [ROUND_W-1:0] round_q;
  logic               ready_q;
  logic               accept;

  assign accept     = in_valid_i && ready_q;
  assign in_ready_o = ready_q;

  // Command decode from the current state.
  always_comb begin
    cmd_o.round = round_q;
    unique case (state_q)
      S_IDLE:    cmd_o.op = accept ? OP_LOAD : OP_NONE;
      S_GAIN_DR: cmd_o.op = OP_GAIN_DR;
      S_FOLD1,
      S_FOLD2:   cmd_o.op = OP_FOLD;
      S_ROT1,
      S_ROT2:    cmd_o.op = OP_ROT;
      S_STEP:    cmd_o.op = OP_STEP;
      S_GAIN_DX: cmd_o.op = OP_GAIN_DX;
      S_GAIN_DY: cmd_o.op = OP_GAIN_DY;
      S_POSE:    cmd_o.op = OP_POSE;
      S_SQX:     cmd_o.op = OP_SQ_X;
      S_SQY:     cmd_o.op = OP_SQ_Y;
      S_SQT:     cmd_o.op = OP_SQ_T;
      S_DONE:    cmd_o.op = status_i.out_busy ? OP_NONE : OP_RESULT;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  // State, round counter and input ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      round_q <= '0;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_GAIN_DR;
            ready_q <= 1'b0;
          end
        end
        S_GAIN_DR: state_q <= S_FOLD1;
        S_FOLD1: begin
          state_q <= S_ROT1;
          round_q <= '0;
        end
        S_ROT1: begin
          if (round_q == ROUND_LAST) begin
            state_q <= S_STEP;
          end
          round_q <= round_q + 1'b1;
        end
        S_STEP:    state_q <= S_GAIN_DX;
        S_GAIN_DX: state_q <= S_GAIN_DY;
        S_GAIN_DY: state_q <= S_FOLD2;
        S_FOLD2: begin
          state_q <= S_ROT2;
          round_q <= '0;
        end
        S_ROT2: begin
          if (round_q == ROUND_LAST) begin
            state_q <= S_POSE;
          end
          round_q <= round_q + 1'b1;
        end
        S_POSE: state_q <= S_SQX;
        S_SQX:  state_q <= S_SQY;
        S_SQY:  state_q <= S_SQT;
        S_SQT:  state_q <= S_DONE;
        S_DONE: begin
          if (!status_i.out_busy) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/poiu_datapath.sv
// Pose registers, shared CORDIC and multiplier, and the result register.
`timescale 1ns / 1ps
module poiu_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  poiu_pkg::cmd_t         cmd_i,
  output poiu_pkg::status_t      status_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  input  logic signed [23:0]     distance_step_i,
  input  logic signed [15:0]     turn_step_i,
  input  logic [31:0]            time_stamp_i,
  input  logic                   restart_i,
  output logic signed [31:0]     pos_x_o,
  output logic signed [31:0]     pos_y_o,
  output logic signed [15:0]     heading_o,
  output logic signed [23:0]     step_dx_o,
  output logic signed [23:0]     step_dy_o,
  output logic                   keyframe_vote_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i
);
  import poiu_pkg::*;

  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'h4000_0000);
  localparam logic signed [ZW-1:0] Z_HALF    = ZW'(64'h8000_0000);
  localparam logic signed [XW-1:0] RND_HALF  = XW'(64'h8000);

  // Saturate a CORDIC output to the step width.
  function automatic logic signed [STEP_W-1:0] sat_step(input logic signed [XW-1:0] v);
    logic signed [STEP_W-1:0] r;
    if ((&v[XW-1:STEP_W-1]) || !(|v[XW-1:STEP_W-1])) begin
      r = v[STEP_W-1:0];
    end else if (v[XW-1]) begin
      r = {1'b1, {(STEP_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STEP_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a position sum to the position width.
  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [POS_BITS-1:0] r;
    if ((&v[SUM_W-1:POS_BITS-1]) || !(|v[SUM_W-1:POS_BITS-1])) begin
      r = v[POS_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(POS_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  logic [30:0] dist_thr_q;
  logic [14:0] ang_thr_q;
  logic [31:0] time_thr_q;

  logic signed [23:0]         dr_q;
  logic signed [ANGLE_BITS-1:0] turn_q;
  logic [31:0]                ts_q;
  logic signed [POS_BITS-1:0] pos_x_q, pos_y_q;
  logic signed [ANGLE_BITS-1:0] head_q;
  logic [31:0]                origin_q;
  logic signed [XW-1:0]       cx_q, cy_q;
  logic signed [ZW-1:0]       cz_q;
  logic signed [STEP_W-1:0]   dx_q, dy_q;
  logic [64:0]                sq_q;
  logic [61:0]                th_q;

  logic signed [31:0] pos_x_out_q, pos_y_out_q;
  logic signed [15:0] heading_out_q;
  logic signed [23:0] dx_out_q, dy_out_q;
  logic               vote_out_q;
  logic               out_valid_q;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [XW-1:0]      gain_v;
  logic signed [XW-1:0]      xs, ys, rnd_x, rnd_y;
  logic signed [ZW-1:0]      atan_z;
  logic [POS_BITS-1:0]       ax, ay;
  logic                      far;
  logic [ANGLE_BITS-1:0]     habs;
  logic [31:0]               elapsed;
  logic                      vote;

  // Magnitudes and keyframe criteria on the current pose.
  always_comb begin
    ax = pos_x_q[POS_BITS-1] ? (~pos_x_q + 1'b1) : pos_x_q;
    ay = pos_y_q[POS_BITS-1] ? (~pos_y_q + 1'b1) : pos_y_q;
    far = ({{(64-POS_BITS){1'b0}}, ax} > 64'h8000_0000) ||
          ({{(64-POS_BITS){1'b0}}, ay} > 64'h8000_0000);
    habs = head_q[ANGLE_BITS-1] ? (~head_q + 1'b1) : head_q;
    elapsed = ts_q - origin_q;
    vote = far || (sq_q > {3'b000, th_q}) ||
           (25'(habs) > 25'(ang_thr_q)) || (elapsed > time_thr_q);
  end

  // Shared multiplier operand selection.
  always_comb begin
    unique case (cmd_i.op)
      OP_GAIN_DR: begin mul_a = MUL_W'(dr_q);              mul_b = GAIN_Q31; end
      OP_GAIN_DX: begin mul_a = MUL_W'(dx_q);              mul_b = GAIN_Q31; end
      OP_GAIN_DY: begin mul_a = MUL_W'(dy_q);              mul_b = GAIN_Q31; end
      OP_SQ_X: begin
        mul_a = signed'({1'b0, 32'(ax)});
        mul_b = signed'({1'b0, 32'(ax)});
      end
      OP_SQ_Y: begin
        mul_a = signed'({1'b0, 32'(ay)});
        mul_b = signed'({1'b0, 32'(ay)});
      end
      OP_SQ_T: begin
        mul_a = signed'({2'b00, dist_thr_q});
        mul_b = signed'({2'b00, dist_thr_q});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p  = mul_a * mul_b;
    gain_v = XW'(mul_p >>> GAIN_SHIFT);
  end

  // CORDIC round terms and output rounding.
  always_comb begin
    xs     = cx_q >>> cmd_i.round;
    ys     = cy_q >>> cmd_i.round;
    atan_z = ZW'(atan_lut(cmd_i.round));
    rnd_x  = (cx_q + RND_HALF) >>> GUARD;
    rnd_y  = (cy_q + RND_HALF) >>> GUARD;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_thr_q <= 31'd65536;
      ang_thr_q  <= 15'd8192;
      time_thr_q <= 32'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIST:  dist_thr_q <= cfg_data_i[30:0];
        CFG_ANGLE: ang_thr_q  <= cfg_data_i[14:0];
        CFG_TIME:  time_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Kept pose and origin time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      head_q   <= '0;
      origin_q <= '0;
    end else if (cmd_i.op == OP_LOAD && restart_i) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      head_q   <= '0;
      origin_q <= time_stamp_i;
    end else if (cmd_i.op == OP_POSE) begin
      pos_x_q <= sat_pos(SUM_W'(pos_x_q) + SUM_W'(rnd_x));
      pos_y_q <= sat_pos(SUM_W'(pos_y_q) + SUM_W'(rnd_y));
      head_q  <= head_q + turn_q;
    end
  end

  // Working registers of the CORDIC and the vote sums.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        dr_q   <= distance_step_i;
        turn_q <= ANGLE_BITS'(turn_step_i);
        ts_q   <= time_stamp_i;
      end
      OP_GAIN_DR: begin
        cx_q <= gain_v;
        cy_q <= '0;
        cz_q <= ZW'(turn_q) <<< HALF_SHIFT;
      end
      OP_FOLD: begin
        if (cz_q > Z_QUARTER) begin
          cx_q <= -cx_q;
          cy_q <= -cy_q;
          cz_q <= cz_q - Z_HALF;
        end else if (cz_q < -Z_QUARTER) begin
          cx_q <= -cx_q;
          cy_q <= -cy_q;
          cz_q <= cz_q + Z_HALF;
        end
      end
      OP_ROT: begin
        if (!cz_q[ZW-1]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atan_z;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atan_z;
        end
      end
      OP_STEP: begin
        dx_q <= sat_step(rnd_x);
        dy_q <= sat_step(rnd_y);
      end
      OP_GAIN_DX: begin
        cx_q <= gain_v;
        cz_q <= ZW'(head_q) <<< HEAD_SHIFT;
      end
      OP_GAIN_DY: cy_q <= gain_v;
      OP_SQ_X:    sq_q <= {1'b0, mul_p[63:0]};
      OP_SQ_Y:    sq_q <= sq_q + {1'b0, mul_p[63:0]};
      OP_SQ_T:    th_q <= mul_p[61:0];
      default: ;
    endcase
  end

  // Result register, free again once the item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_RESULT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RESULT) begin
      pos_x_out_q   <= 32'(pos_x_q);
      pos_y_out_q   <= 32'(pos_y_q);
      heading_out_q <= 16'(head_q);
      dx_out_q      <= dx_q;
      dy_out_q      <= dy_q;
      vote_out_q    <= vote;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = pos_x_out_q;
  assign pos_y_o         = pos_y_out_q;
  assign heading_o       = heading_out_q;
  assign step_dx_o       = dx_out_q;
  assign step_dy_o       = dy_out_q;
  assign keyframe_vote_o = vote_out_q;

endmodule

FILE: rtl/planar_odometry_integrator_unit.sv
// Top level of the planar odometry integrator.
//
//   Channel  Dir  Handshake             Contents
//   s_axis   in   tvalid/tready         odometry step item
//   m_axis   out  tvalid/tready         pose and keyframe vote item
//   cfg      in   cfg_we_i              threshold register write
//
// The work on one item, from acceptance to its result being written, is done by
// two passes of 24 rounds through the single shared CORDIC stage
// and a shared 33x33 multiplier used for gains and squared distances.
// The block takes no new item while one is still in progress.
// The result waits in an output register; a stalled output holds only
// the final write, and the next item is accepted once the result is stored.
// Reset is asynchronous and active low; it clears the pose and sets the thresholds to their defaults.
`timescale 1ns / 1ps
`include "planar_odometry_integrator_unit_defines.svh"
module planar_odometry_integrator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // distance_step[23:0], turn_step[39:24], time_stamp[71:40]
  input  logic [71:0]  s_axis_tdata,
  // restart[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[31:0], pos_y[63:32], heading[79:64], step_dx[103:80], step_dy[127:104]
  output logic [127:0] m_axis_tdata,
  // keyframe_vote[0]
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import poiu_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic signed [31:0] pos_x, pos_y;
  logic signed [15:0] heading;
  logic signed [23:0] step_dx, step_dy;

  // Sequencer.
  poiu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and state.
  poiu_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .distance_step_i (signed'(s_axis_tdata[23:0])),
    .turn_step_i     (signed'(s_axis_tdata[39:24])),
    .time_stamp_i    (s_axis_tdata[71:40]),
    .restart_i       (s_axis_tuser),
    .pos_x_o         (pos_x),
    .pos_y_o         (pos_y),
    .heading_o       (heading),
    .step_dx_o       (step_dx),
    .step_dy_o       (step_dy),
    .keyframe_vote_o (m_axis_tuser),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready)
  );

  assign m_axis_tdata = {step_dy, step_dx, heading, pos_y, pos_x};

  // The block goes busy after taking an item, and is ready again only with a result stored.
  `POIU_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
  `POIU_ASSERT_IMP(a_ready_with_result, $rose(s_axis_tready), m_axis_tvalid, "ready without result")

endmodule

FILE: verif/odometry_checker.sv
// Pose predictor and result scoreboard for the planar odometry integrator.
`timescale 1ns / 1ps
module odometry_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  output int           pending_o,
  output int           errors_o
);
  import poiu_pkg::*;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
    logic [23:0] step_dx;
    logic [23:0] step_dy;
    logic        vote;
  } pose_t;

  localparam longint GAIN = 64'sd1304065748;
  localparam longint ATAN [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  logic [30:0] dist_thr;
  logic [14:0] ang_thr;
  logic [31:0] time_thr;
  longint      pose_x, pose_y;
  logic signed [15:0] pose_h;
  logic [31:0] origin_ts;
  pose_t       pose_q[$];

  assign pending_o = pose_q.size();

  // Gain-compensated CORDIC rotation of (vx, vy) by 32-bit binary angle z.
  function automatic void rotate_vec(input longint vx, input longint vy, input longint z,
                                     output longint ox, output longint oy);
    longint x, y, xs, ys;
    x = (vx * GAIN) >>> (31 - GUARD);
    y = (vy * GAIN) >>> (31 - GUARD);
    if (z > (64'sd1 <<< 30)) begin
      x = -x; y = -y; z = z - (64'sd1 <<< 31);
    end else if (z < -(64'sd1 <<< 30)) begin
      x = -x; y = -y; z = z + (64'sd1 <<< 31);
    end
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ATAN[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ATAN[i];
      end
    end
    ox = (x + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
    oy = (y + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
  endfunction

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Advance the pose by one odometry step and return the expected result.
  function automatic pose_t advance_pose(input logic [71:0] d, input logic rs);
    pose_t  p;
    longint dr, turn, dx, dy, rx, ry, ax, ay, h;
    longint unsigned d2, th2;
    logic [31:0] ts;
    dr   = longint'($signed(d[23:0]));
    turn = longint'($signed(d[39:24]));
    ts   = d[71:40];
    if (rs) begin
      pose_x = 0; pose_y = 0; pose_h = 0; origin_ts = ts;
    end
    rotate_vec(dr, 0, turn * 32768, dx, dy);
    dx = clamp(dx, 24);
    dy = clamp(dy, 24);
    rotate_vec(dx, dy, longint'(pose_h) * 65536, rx, ry);
    pose_x = clamp(pose_x + rx, POS_BITS);
    pose_y = clamp(pose_y + ry, POS_BITS);
    pose_h = pose_h + 16'(turn);
    ax = pose_x < 0 ? -pose_x : pose_x;
    ay = pose_y < 0 ? -pose_y : pose_y;
    th2 = longint'(dist_thr) * longint'(dist_thr);
    d2 = ax * ax + ay * ay;
    h = pose_h < 0 ? -longint'(pose_h) : longint'(pose_h);
    p.vote = (d2 > th2) || (h > longint'(ang_thr)) || ((ts - origin_ts) > time_thr);
    p.pos_x   = pose_x[31:0];
    p.pos_y   = pose_y[31:0];
    p.heading = pose_h;
    p.step_dx = dx[23:0];
    p.step_dy = dy[23:0];
    return p;
  endfunction

  // Track register writes, predict on accepted inputs, compare accepted outputs.
  always @(posedge clk_i or negedge rst_ni) begin
    pose_t exp_p, got;
    if (!rst_ni) begin
      dist_thr = 31'd65536; ang_thr = 15'd8192; time_thr = 32'd1000;
      pose_x = 0; pose_y = 0; pose_h = 0; origin_ts = 0;
      errors_o = 0;
      pose_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DIST:  dist_thr = cfg_data_i[30:0];
          CFG_ANGLE: ang_thr  = cfg_data_i[14:0];
          CFG_TIME:  time_thr = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[79:64],
               m_axis_tdata[103:80], m_axis_tdata[127:104], m_axis_tuser};
        if (pose_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          errors_o++;
        end else begin
          exp_p = pose_q.pop_front();
          if (got.pos_x !== exp_p.pos_x) begin
            $display("%0t: pos_x expected %h actual %h", $time, exp_p.pos_x, got.pos_x);
            errors_o++;
          end
          if (got.pos_y !== exp_p.pos_y) begin
            $display("%0t: pos_y expected %h actual %h", $time, exp_p.pos_y, got.pos_y);
            errors_o++;
          end
          if (got.heading !== exp_p.heading) begin
            $display("%0t: heading expected %h actual %h", $time, exp_p.heading,
                     got.heading);
            errors_o++;
          end
          if (got.step_dx !== exp_p.step_dx) begin
            $display("%0t: step_dx expected %h actual %h", $time, exp_p.step_dx,
                     got.step_dx);
            errors_o++;
          end
          if (got.step_dy !== exp_p.step_dy) begin
            $display("%0t: step_dy expected %h actual %h", $time, exp_p.step_dy,
                     got.step_dy);
            errors_o++;
          end
          if (got.vote !== exp_p.vote) begin
            $display("%0t: keyframe_vote expected %b actual %b", $time, exp_p.vote,
                     got.vote);
            errors_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pose_q.push_back(advance_pose(s_axis_tdata, s_axis_tuser));
    end
  end
endmodule

FILE: verif/tb_top.sv
// Stimulus and verdict for the planar odometry integrator testbench.
`timescale 1ns / 1ps
module tb_top;
  import poiu_pkg::*;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [71:0]  s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [127:0] m_axis_tdata;
  logic         cfg_we_i;
  logic [1:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;
  int           pending, errors;
  int           tx_idle_pct, rx_idle_pct;
  logic [31:0]  stamp;

  planar_odometry_integrator_unit i_dut (.*);

  odometry_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_index_i, .cfg_data_i, .pending_o(pending), .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Send one odometry step item, with an optional idle gap before it.
  task automatic send_step(input logic [23:0] dr, input logic [15:0] turn,
                           input logic [31:0] ts, input logic rs);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ts, turn, dr};
    s_axis_tuser  <= rs;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending until every expected result has come, then let the block settle.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random step: moderate, extreme or full-range motion, with occasional restarts.
  task automatic random_step;
    logic [23:0] dr;
    logic [15:0] turn;
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) dr = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
    else if (sel < 60) dr = 24'($signed($urandom_range(131072)) - 65536);
    else dr = 24'($urandom);
    sel = $urandom_range(99);
    if (sel < 10) turn = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    else if (sel < 30) turn = 16'h0;
    else if (sel < 70) turn = 16'($signed($urandom_range(2048)) - 1024);
    else turn = 16'($urandom);
    if ($urandom_range(99) < 5) stamp = $urandom;
    else stamp = stamp + $urandom_range(200);
    send_step(dr, turn, stamp, $urandom_range(99) < 4);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_DIST;
    cfg_data_i    = '0;
    tx_idle_pct   = 30;
    rx_idle_pct   = 75;
    stamp         = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (70) @(posedge clk_i);

    // Directed part under reset thresholds: field extremes, wraps and saturation.
    send_step(24'h000000, 16'h0000, 32'd0, 1'b0);
    send_step(24'h7FFFFF, 16'h0000, 32'd10, 1'b1);
    send_step(24'h800000, 16'h0000, 32'd20, 1'b0);
    send_step(24'h7FFFFF, 16'h7FFF, 32'd30, 1'b0);
    send_step(24'h800000, 16'h8000, 32'd40, 1'b0);
    send_step(24'h7FFFFF, 16'h4000, 32'd50, 1'b0);
    send_step(24'h7FFFFF, 16'hC000, 32'd60, 1'b0);
    send_step(24'h010000, 16'h7000, 32'd70, 1'b0);
    send_step(24'h010000, 16'h7000, 32'd80, 1'b0);
    send_step(24'hFFFFFF, 16'hFFFF, 32'hFFFF_FFF0, 1'b1);
    send_step(24'h000001, 16'h0001, 32'h0000_0400, 1'b0);
    send_step(24'h123456, 16'h2000, 32'hFFFF_FFFF, 1'b0);
    drain();

    // Phase with all thresholds at their lowest.
    write_cfg(CFG_DIST, 32'd0);
    write_cfg(CFG_ANGLE, 32'd0);
    write_cfg(CFG_TIME, 32'd0);
    for (int n = 0; n < 120; n++) random_step();
    drain();

    // Phase with all thresholds at their highest; sender and receiver swap.
    write_cfg(CFG_DIST, 32'h7FFF_FFFF);
    write_cfg(CFG_ANGLE, 32'h0000_7FFF);
    write_cfg(CFG_TIME, 32'hFFFF_FFFF);
    tx_idle_pct = 75;
    rx_idle_pct = 30;
    for (int n = 0; n < 220; n++) random_step();
    drain();

    // Phase with random thresholds and no idling.
    write_cfg(CFG_DIST, {1'b0, 31'($urandom_range(32'h0040_0000))});
    write_cfg(CFG_ANGLE, $urandom_range(16384));
    write_cfg(CFG_TIME, $urandom_range(3000));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int n = 0; n < 200; n++) random_step();
    // Drive straight far enough that both positions saturate.
    send_step(24'h7FFFFF, 16'h2000, stamp, 1'b1);
    for (int n = 0; n < 400; n++) send_step(24'h7FFFFF, 16'h0000, stamp, 1'b0);
    drain();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/poiu_pkg.sv
rtl/poiu_ctrl.sv
rtl/poiu_datapath.sv
rtl/planar_odometry_integrator_unit.sv
verif/odometry_checker.sv
verif/tb_top.sv
